// ----- design/hjmc_pkg.sv -----
// hjmc_pkg: shared types and constants for the hjorth mobility/complexity core
// used by every module of the design; depends on nothing
`timescale 1ns / 1ps

package hjmc_pkg;

	// fixed port field widths
	localparam int IN_W  = 16;
	localparam int RES_W = 32;
	localparam int ST_W  = 2;
	localparam int OUT_W = 72;
	// a quotient at or above 2^QUO_W gives a saturated root
	localparam int QUO_W = 64;

	// operations of the shared arithmetic unit
	localparam logic [1:0] OP_MUL  = 2'd0;
	localparam logic [1:0] OP_SUB  = 2'd1;
	localparam logic [1:0] OP_DIV  = 2'd2;
	localparam logic [1:0] OP_SQRT = 2'd3;

	// result status codes
	localparam logic [ST_W-1:0] STAT_OK    = 2'd0;
	localparam logic [ST_W-1:0] STAT_SHORT = 2'd1;
	localparam logic [ST_W-1:0] STAT_NOCPX = 2'd2;
	localparam logic [ST_W-1:0] STAT_OVF   = 2'd3;

	// command into the arithmetic unit
	typedef struct packed {
		logic       start;
		logic [1:0] op;
	} hjmc_cmd_t;

endpackage

// ----- design/hjmc_arith.sv -----
// hjmc_arith: shared iterative unit, one wide add/subtract reused for
// shift-add multiply, clamped subtract, restoring divide and integer root; uses hjmc_pkg
`timescale 1ns / 1ps

module hjmc_arith #(
	parameter int BW = 236
) (
	input  logic              clk,
	input  logic              arst_n,
	input  hjmc_pkg::hjmc_cmd_t cmd,
	input  logic [BW-1:0]     opa,
	input  logic [BW-1:0]     opb,
	output logic              done,
	output logic [BW-1:0]     result
);
	import hjmc_pkg::*;

	localparam int CW = $clog2(BW + 1);

	logic [1:0]    op_q;
	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [BW-1:0] x_q;
	logic [BW-1:0] y_q;
	logic [BW-1:0] acc_q;
	logic [BW:0]   rem_q;

	logic [BW+1:0] ra;
	logic [BW+1:0] rb;
	logic          sub;
	logic [BW+1:0] res;
	logic          ge;
	logic          last_step;

	// operand select for the shared adder
	always_comb begin
		case (op_q)
			OP_MUL: begin
				ra  = {2'b00, acc_q};
				rb  = {2'b00, x_q};
				sub = 1'b0;
			end
			OP_SUB: begin
				ra  = {2'b00, x_q};
				rb  = {2'b00, y_q};
				sub = 1'b1;
			end
			OP_DIV: begin
				ra  = {1'b0, rem_q[BW-1:0], x_q[BW-1]};
				rb  = {2'b00, y_q};
				sub = 1'b1;
			end
			default: begin
				ra  = {1'b0, rem_q[BW-2:0], x_q[BW-1:BW-2]};
				rb  = {1'b0, acc_q[BW-2:0], 2'b01};
				sub = 1'b1;
			end
		endcase
	end

	assign res       = ra + (rb ^ {(BW+2){sub}}) + (BW+2)'(sub);
	assign ge        = ~res[BW+1];
	assign last_step = (cnt_q == CW'(1));

	// control: busy, done pulse, iteration count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= OP_MUL;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				op_q   <= cmd.op;
				busy_q <= 1'b1;
				cnt_q  <= (cmd.op == OP_SQRT) ? CW'(BW / 2) : CW'(BW);
			end else if (busy_q) begin
				case (op_q)
					OP_MUL: begin
						if (y_q == '0) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
					OP_SUB: begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
					default: begin
						cnt_q <= cnt_q - CW'(1);
						if (last_step) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q   <= opa;
			y_q   <= opb;
			acc_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			case (op_q)
				OP_MUL: begin
					if (y_q[0])
						acc_q <= res[BW-1:0];
					x_q <= {x_q[BW-2:0], 1'b0};
					y_q <= {1'b0, y_q[BW-1:1]};
				end
				OP_SUB: begin
					acc_q <= ge ? res[BW-1:0] : '0;
				end
				OP_DIV: begin
					rem_q <= ge ? res[BW:0] : ra[BW:0];
					acc_q <= {acc_q[BW-2:0], ge};
					x_q   <= {x_q[BW-2:0], 1'b0};
				end
				default: begin
					rem_q <= ge ? res[BW:0] : ra[BW:0];
					acc_q <= {acc_q[BW-2:0], ge};
					x_q   <= {x_q[BW-3:0], 2'b00};
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = acc_q;

endmodule

// ----- design/hjmc_accum.sv -----
// hjmc_accum: sample history, count and the six running sums, with a
// two-stage square pipeline; uses hjmc_pkg
`timescale 1ns / 1ps

module hjmc_accum #(
	parameter int SB      = 16,
	parameter int CB      = 17,
	parameter int MAX_LEN = 65536
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  logic [hjmc_pkg::IN_W-1:0]    sample,
	input  logic                         clr,
	output logic                         busy,
	output logic [CB-1:0]                n,
	output logic                         ovf,
	output logic signed [SB+CB-1:0]      sum0,
	output logic signed [SB+CB:0]        sum1,
	output logic signed [SB+CB+1:0]      sum2,
	output logic [2*SB+CB-1:0]           sq0,
	output logic [2*SB+CB+1:0]           sq1,
	output logic [2*SB+CB+3:0]           sq2
);
	import hjmc_pkg::*;

	logic signed [SB-1:0]   x;
	logic signed [SB:0]     d1;
	logic signed [SB+1:0]   d2;
	logic                   room;

	logic signed [SB-1:0]   prev_q;
	logic signed [SB-1:0]   prev2_q;
	logic [CB-1:0]          cnt_q;
	logic                   ovf_q;
	logic signed [SB+CB-1:0] sum0_q;
	logic signed [SB+CB:0]   sum1_q;
	logic signed [SB+CB+1:0] sum2_q;
	logic [2*SB+CB-1:0]     sq0_q;
	logic [2*SB+CB+1:0]     sq1_q;
	logic [2*SB+CB+3:0]     sq2_q;

	logic                   vld_s1, en1_s1, en2_s1;
	logic signed [SB-1:0]   x_s1;
	logic signed [SB:0]     d1_s1;
	logic signed [SB+1:0]   d2_s1;
	logic                   vld_s2, en1_s2, en2_s2;
	logic [2*SB-1:0]        q0_s2;
	logic [2*SB+1:0]        q1_s2;
	logic [2*SB+3:0]        q2_s2;
	logic signed [2*SB-1:0] p0;
	logic signed [2*SB+1:0] p1;
	logic signed [2*SB+3:0] p2;

	// low sample bits taken as two's complement
	assign x    = SB'(sample);
	assign d1   = (SB+1)'(x) - (SB+1)'(prev_q);
	assign d2   = (SB+2)'(x) - ((SB+2)'(prev_q) <<< 1) + (SB+2)'(prev2_q);
	assign room = (cnt_q < CB'(MAX_LEN));

	// squares, one multiplier per difference order
	assign p0 = x_s1 * x_s1;
	assign p1 = d1_s1 * d1_s1;
	assign p2 = d2_s1 * d2_s1;

	// history, count, sums and square sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			prev2_q <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			sum0_q  <= '0;
			sum1_q  <= '0;
			sum2_q  <= '0;
			sq0_q   <= '0;
			sq1_q   <= '0;
			sq2_q   <= '0;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
		end else if (clr) begin
			prev_q  <= '0;
			prev2_q <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			sum0_q  <= '0;
			sum1_q  <= '0;
			sum2_q  <= '0;
			sq0_q   <= '0;
			sq1_q   <= '0;
			sq2_q   <= '0;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
		end else begin
			vld_s1 <= take && room;
			vld_s2 <= vld_s1;
			if (take) begin
				if (!room) begin
					ovf_q <= 1'b1;
				end else begin
					sum0_q <= sum0_q + (SB+CB)'(x);
					if (cnt_q >= CB'(1))
						sum1_q <= sum1_q + (SB+CB+1)'(d1);
					if (cnt_q >= CB'(2))
						sum2_q <= sum2_q + (SB+CB+2)'(d2);
					prev2_q <= prev_q;
					prev_q  <= x;
					cnt_q   <= cnt_q + CB'(1);
				end
			end
			if (vld_s2) begin
				sq0_q <= sq0_q + (2*SB+CB)'(q0_s2);
				if (en1_s2)
					sq1_q <= sq1_q + (2*SB+CB+2)'(q1_s2);
				if (en2_s2)
					sq2_q <= sq2_q + (2*SB+CB+4)'(q2_s2);
			end
		end
	end

	// square pipeline payload
	always_ff @(posedge clk) begin
		x_s1   <= x;
		d1_s1  <= d1;
		d2_s1  <= d2;
		en1_s1 <= (cnt_q >= CB'(1));
		en2_s1 <= (cnt_q >= CB'(2));
		q0_s2  <= p0;
		q1_s2  <= p1;
		q2_s2  <= p2;
		en1_s2 <= en1_s1;
		en2_s2 <= en2_s1;
	end

	assign busy = vld_s1 | vld_s2;
	assign n    = cnt_q;
	assign ovf  = ovf_q;
	assign sum0 = sum0_q;
	assign sum1 = sum1_q;
	assign sum2 = sum2_q;
	assign sq0  = sq0_q;
	assign sq1  = sq1_q;
	assign sq2  = sq2_q;

endmodule

// ----- design/hjmc_seq.sv -----
// hjmc_seq: closing sequencer, runs the variance, ratio and root program
// on the shared unit; uses hjmc_pkg and hjmc_arith
`timescale 1ns / 1ps

module hjmc_seq #(
	parameter int SB = 16,
	parameter int CB = 17,
	parameter int FB = 16,
	parameter int BW = 236
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [CB-1:0]                n,
	input  logic                         ovf,
	input  logic signed [SB+CB-1:0]      sum0,
	input  logic signed [SB+CB:0]        sum1,
	input  logic signed [SB+CB+1:0]      sum2,
	input  logic [2*SB+CB-1:0]           sq0,
	input  logic [2*SB+CB+1:0]           sq1,
	input  logic [2*SB+CB+3:0]           sq2,
	output logic                         done,
	output logic [hjmc_pkg::RES_W-1:0]   mobility,
	output logic [hjmc_pkg::RES_W-1:0]   complexity,
	output logic [hjmc_pkg::ST_W-1:0]    status
);
	import hjmc_pkg::*;

	// sequencer states
	localparam logic [1:0] Q_IDLE  = 2'd0;
	localparam logic [1:0] Q_ISSUE = 2'd1;
	localparam logic [1:0] Q_WAIT  = 2'd2;

	// program steps
	localparam logic [4:0] P_SQ0 = 5'd0;
	localparam logic [4:0] P_MS0 = 5'd1;
	localparam logic [4:0] P_A0  = 5'd2;
	localparam logic [4:0] P_SQ1 = 5'd3;
	localparam logic [4:0] P_MS1 = 5'd4;
	localparam logic [4:0] P_A1  = 5'd5;
	localparam logic [4:0] P_P0  = 5'd6;
	localparam logic [4:0] P_P1  = 5'd7;
	localparam logic [4:0] P_MN  = 5'd8;
	localparam logic [4:0] P_MD  = 5'd9;
	localparam logic [4:0] P_MQ  = 5'd10;
	localparam logic [4:0] P_MR  = 5'd11;
	localparam logic [4:0] P_SQ2 = 5'd12;
	localparam logic [4:0] P_MS2 = 5'd13;
	localparam logic [4:0] P_A2  = 5'd14;
	localparam logic [4:0] P_P2  = 5'd15;
	localparam logic [4:0] P_CN0 = 5'd16;
	localparam logic [4:0] P_CN1 = 5'd17;
	localparam logic [4:0] P_CN2 = 5'd18;
	localparam logic [4:0] P_CD0 = 5'd19;
	localparam logic [4:0] P_CD1 = 5'd20;
	localparam logic [4:0] P_CD2 = 5'd21;
	localparam logic [4:0] P_CQ  = 5'd22;
	localparam logic [4:0] P_CR  = 5'd23;

	logic [1:0]          state_q;
	logic [4:0]          step_q;
	logic                done_q;
	logic [BW-1:0]       a0_q, a1_q, a2_q, t_q, nm_q, dn_q, p0_q, p1_q, p2_q;
	logic [RES_W-1:0]    mob_q, cpx_q;
	logic [ST_W-1:0]     st_q;

	logic [CB-1:0]       n1, n2, n3;
	logic [SB+CB-1:0]    m0;
	logic [SB+CB:0]      m1;
	logic [SB+CB+1:0]    m2;
	hjmc_cmd_t           cmd;
	logic [BW-1:0]       opa, opb;
	logic                u_done;
	logic [BW-1:0]       u_res;
	logic [RES_W-1:0]    root;
	logic                finish;

	assign n1 = n - CB'(1);
	assign n2 = n - CB'(2);
	assign n3 = n - CB'(3);
	assign m0 = sum0[SB+CB-1] ? (SB+CB)'(-sum0) : (SB+CB)'(sum0);
	assign m1 = sum1[SB+CB]   ? (SB+CB+1)'(-sum1) : (SB+CB+1)'(sum1);
	assign m2 = sum2[SB+CB+1] ? (SB+CB+2)'(-sum2) : (SB+CB+2)'(sum2);

	// operation and operands of each step
	always_comb begin
		cmd.start = (state_q == Q_ISSUE);
		cmd.op    = OP_MUL;
		opa       = '0;
		opb       = '0;
		case (step_q)
			P_SQ0: begin opa = BW'(sq0); opb = BW'(n); end
			P_MS0: begin opa = BW'(m0); opb = BW'(m0); end
			P_A0:  begin cmd.op = OP_SUB; opa = t_q; opb = dn_q; end
			P_SQ1: begin opa = BW'(sq1); opb = BW'(n1); end
			P_MS1: begin opa = BW'(m1); opb = BW'(m1); end
			P_A1:  begin cmd.op = OP_SUB; opa = t_q; opb = dn_q; end
			P_P0:  begin opa = BW'(n); opb = BW'(n1); end
			P_P1:  begin opa = BW'(n1); opb = BW'(n2); end
			P_MN:  begin opa = a1_q; opb = p0_q; end
			P_MD:  begin opa = a0_q; opb = p1_q; end
			P_MQ:  begin cmd.op = OP_DIV; opa = {nm_q[BW-1-2*FB:0], {(2*FB){1'b0}}}; opb = dn_q; end
			P_MR:  begin cmd.op = OP_SQRT; opa = t_q; end
			P_SQ2: begin opa = BW'(sq2); opb = BW'(n2); end
			P_MS2: begin opa = BW'(m2); opb = BW'(m2); end
			P_A2:  begin cmd.op = OP_SUB; opa = t_q; opb = dn_q; end
			P_P2:  begin opa = BW'(n2); opb = BW'(n3); end
			P_CN0: begin opa = a2_q; opb = a0_q; end
			P_CN1: begin opa = nm_q; opb = p1_q; end
			P_CN2: begin opa = nm_q; opb = p1_q; end
			P_CD0: begin opa = a1_q; opb = a1_q; end
			P_CD1: begin opa = dn_q; opb = p2_q; end
			P_CD2: begin opa = dn_q; opb = p0_q; end
			P_CQ:  begin cmd.op = OP_DIV; opa = {nm_q[BW-1-2*FB:0], {(2*FB){1'b0}}}; opb = dn_q; end
			P_CR:  begin cmd.op = OP_SQRT; opa = t_q; end
			default: begin cmd.op = OP_SUB; end
		endcase
	end

	// root with zero-denominator and saturation rules
	assign root   = (dn_q == '0) ? '0 :
			(|t_q[BW-1:QUO_W]) ? {RES_W{1'b1}} : u_res[RES_W-1:0];
	assign finish = (step_q == P_CR) || ((step_q == P_MR) && (n == CB'(3)));

	hjmc_arith #(.BW(BW)) u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.opa    (opa),
		.opb    (opb),
		.done   (u_done),
		.result (u_res)
	);

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= Q_IDLE;
			step_q  <= P_SQ0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				Q_IDLE: begin
					if (start) begin
						step_q <= P_SQ0;
						if (ovf || n < CB'(3))
							done_q <= 1'b1;
						else
							state_q <= Q_ISSUE;
					end
				end
				Q_ISSUE: begin
					state_q <= Q_WAIT;
				end
				Q_WAIT: begin
					if (u_done) begin
						if (finish) begin
							state_q <= Q_IDLE;
							done_q  <= 1'b1;
						end else begin
							step_q  <= step_q + 5'd1;
							state_q <= Q_ISSUE;
						end
					end
				end
				default: begin
					state_q <= Q_IDLE;
				end
			endcase
		end
	end

	// step results and the closing values
	always_ff @(posedge clk) begin
		if (state_q == Q_IDLE && start) begin
			mob_q <= '0;
			cpx_q <= '0;
			if (ovf)
				st_q <= STAT_OVF;
			else if (n < CB'(3))
				st_q <= STAT_SHORT;
			else if (n == CB'(3))
				st_q <= STAT_NOCPX;
			else
				st_q <= STAT_OK;
		end else if (state_q == Q_WAIT && u_done) begin
			case (step_q)
				P_SQ0, P_SQ1, P_SQ2, P_MQ, P_CQ: t_q <= u_res;
				P_MS0, P_MS1, P_MS2, P_MD, P_CD0, P_CD1, P_CD2: dn_q <= u_res;
				P_A0:  a0_q <= u_res;
				P_A1:  a1_q <= u_res;
				P_A2:  a2_q <= u_res;
				P_P0:  p0_q <= u_res;
				P_P1:  p1_q <= u_res;
				P_P2:  p2_q <= u_res;
				P_MN, P_CN0, P_CN1, P_CN2: nm_q <= u_res;
				P_MR:  mob_q <= root;
				P_CR:  cpx_q <= root;
				default: begin
				end
			endcase
		end
	end

	assign done       = done_q;
	assign mobility   = mob_q;
	assign complexity = cpx_q;
	assign status     = st_q;

endmodule

// ----- design/hjorth_mobility_complexity_core.sv -----
// Hjorth mobility and complexity core: one sample transfer per cycle while an
// epoch streams in; after the last sample the input stalls for the square pipeline
// drain, the closing program and the load of the result register (a short or
// saturated epoch skips the program). The program runs on one shared add/subtract
// unit: up to 17 shift-add multiplies, each running over the bits of its second
// operand, 3 clamped subtracts, 2 divides and 2 roots, all BW = 8*CB+4*SB+4+2*FB
// bits wide (236 at defaults); a result still waiting in the output register holds
// off the next epoch. Reset is asynchronous and clears all sums and control at once,
// no clearing pass.
`timescale 1ns / 1ps

module hjorth_mobility_complexity_core #(
	parameter int SAMPLE_BITS = 16,
	parameter int MAX_LEN     = 65536,
	parameter int FRAC_BITS   = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [hjmc_pkg::IN_W-1:0]    s_axis_tdata,   // sample
	input  logic                         s_axis_tlast,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [hjmc_pkg::OUT_W-1:0]   m_axis_tdata    // mobility, complexity, status
);
	import hjmc_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int CB = $clog2(MAX_LEN + 1);
	localparam int FB = FRAC_BITS;
	localparam int BW = 8 * CB + 4 * SB + 4 + 2 * FB;

	// top-level states
	localparam logic [1:0] S_ACC   = 2'd0;
	localparam logic [1:0] S_DRAIN = 2'd1;
	localparam logic [1:0] S_CALC  = 2'd2;
	localparam logic [1:0] S_WAIT  = 2'd3;

	logic [1:0]              state_q;
	logic                    out_valid_q;
	logic [RES_W-1:0]        out_mob_q, out_cpx_q;
	logic [ST_W-1:0]         out_st_q;

	logic                    take;
	logic                    acc_busy;
	logic                    seq_start;
	logic                    seq_done;
	logic                    load;
	logic [CB-1:0]           n;
	logic                    ovf;
	logic signed [SB+CB-1:0] sum0;
	logic signed [SB+CB:0]   sum1;
	logic signed [SB+CB+1:0] sum2;
	logic [2*SB+CB-1:0]      sq0;
	logic [2*SB+CB+1:0]      sq1;
	logic [2*SB+CB+3:0]      sq2;
	logic [RES_W-1:0]        mob, cpx;
	logic [ST_W-1:0]         st;

	assign s_axis_tready = (state_q == S_ACC);
	assign take          = s_axis_tvalid & s_axis_tready;
	assign seq_start     = (state_q == S_DRAIN) && !acc_busy;
	assign load          = (state_q == S_WAIT) && !out_valid_q;

	hjmc_accum #(.SB(SB), .CB(CB), .MAX_LEN(MAX_LEN)) u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.sample (s_axis_tdata),
		.clr    (seq_done),
		.busy   (acc_busy),
		.n      (n),
		.ovf    (ovf),
		.sum0   (sum0),
		.sum1   (sum1),
		.sum2   (sum2),
		.sq0    (sq0),
		.sq1    (sq1),
		.sq2    (sq2)
	);

	hjmc_seq #(.SB(SB), .CB(CB), .FB(FB), .BW(BW)) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (seq_start),
		.n          (n),
		.ovf        (ovf),
		.sum0       (sum0),
		.sum1       (sum1),
		.sum2       (sum2),
		.sq0        (sq0),
		.sq1        (sq1),
		.sq2        (sq2),
		.done       (seq_done),
		.mobility   (mob),
		.complexity (cpx),
		.status     (st)
	);

	// epoch flow control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_ACC;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_ACC:   if (take && s_axis_tlast) state_q <= S_DRAIN;
				S_DRAIN: if (!acc_busy) state_q <= S_CALC;
				S_CALC:  if (seq_done) state_q <= S_WAIT;
				S_WAIT:  if (!out_valid_q) state_q <= S_ACC;
				default: state_q <= S_ACC;
			endcase
			if (load)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (load) begin
			out_mob_q <= mob;
			out_cpx_q <= cpx;
			out_st_q  <= st;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_W - 2 * RES_W - ST_W){1'b0}}, out_st_q, out_cpx_q, out_mob_q};

	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		seq_done |-> (state_q == S_CALC))
		else $error("closing program finished outside the calc state");

	a_start_drained: assert property (@(posedge clk) disable iff (!arst_n)
		seq_start |-> !acc_busy)
		else $error("closing program started before the square pipeline drained");

	a_wait_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WAIT && !out_valid_q) |=> (out_valid_q && state_q == S_ACC))
		else $error("finished result was not moved into the output register");

endmodule

// ----- bench/tb_hjorth_mobility_complexity_core.sv -----
// tb_hjorth_mobility_complexity_core: checks per-epoch hjorth mobility, complexity and status
// against an in-bench wide-integer predictor; random epochs, stalls and idling on both sides
// depends on hjmc_pkg and hjorth_mobility_complexity_core
`timescale 1ns / 1ps

module tb_hjorth_mobility_complexity_core;
	import hjmc_pkg::*;

	localparam int SAMPLE_BITS = 16;
	localparam int MAX_LEN     = 65536;
	localparam int FRAC_BITS   = 16;
	localparam int WIDE        = 384;

	typedef logic [WIDE-1:0] wide_t;

	typedef struct {
		logic [IN_W-1:0] sample;
		logic            last;
		bit              drain_first;
	} sample_item_t;

	typedef struct {
		logic [RES_W-1:0] mobility;
		logic [RES_W-1:0] complexity;
		logic [ST_W-1:0]  status;
	} epoch_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [IN_W-1:0]      s_axis_tdata;   // sample
	logic                 s_axis_tlast;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [OUT_W-1:0]     m_axis_tdata;   // mobility, complexity, status

	sample_item_t  pending_samples[$];
	epoch_result_t expected_results[$];
	sample_item_t  offered;
	int            error_count;
	int            cycle_count;
	int            accepted_count;
	int            hold_cycles;
	bit            hold_done;

	// epoch accumulators of the predictor
	longint        prev_x, prev2_x;
	int            epoch_len;
	longint        x_sum, d1_sum, d2_sum;
	wide_t         x_sq_sum, d1_sq_sum, d2_sq_sum;
	bit            len_overflow;

	hjorth_mobility_complexity_core #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.MAX_LEN(MAX_LEN),
		.FRAC_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint magnitude(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic void clear_epoch();
		prev_x = 0;
		prev2_x = 0;
		epoch_len = 0;
		x_sum = 0;
		d1_sum = 0;
		d2_sum = 0;
		x_sq_sum = '0;
		d1_sq_sum = '0;
		d2_sq_sum = '0;
		len_overflow = 1'b0;
	endfunction

	// n*sumsq - sum^2, clamped at zero
	function automatic wide_t unbiased_spread(longint n, longint sum, wide_t sq);
		wide_t r, s;
		r = sq * wide_t'(n);
		s = wide_t'(magnitude(sum)) * wide_t'(magnitude(sum));
		return (r < s) ? '0 : r - s;
	endfunction

	function automatic logic [31:0] int_sqrt(logic [63:0] v);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res[31:0];
	endfunction

	// floor(sqrt(num/den) * 2^FRAC_BITS), saturated, zero for a zero denominator
	function automatic logic [31:0] root_of_ratio(wide_t num, wide_t den);
		wide_t q;
		if (den == 0) return '0;
		q = (num << (2 * FRAC_BITS)) / den;
		if ((q >> QUO_W) != 0) return 32'hFFFF_FFFF;
		return int_sqrt(q[63:0]);
	endfunction

	// advance the epoch by one accepted sample, queue the result on the last one
	function automatic void predict_sample(logic [IN_W-1:0] raw, logic last);
		longint x, d;
		longint n, p0, p1, p2;
		wide_t a0, a1, a2, num, den;
		epoch_result_t res;
		x = longint'($signed(raw[SAMPLE_BITS-1:0]));
		if (epoch_len >= MAX_LEN) begin
			len_overflow = 1'b1;
		end else begin
			x_sum += x;
			x_sq_sum += wide_t'(magnitude(x) * magnitude(x));
			if (epoch_len >= 1) begin
				d = x - prev_x;
				d1_sum += d;
				d1_sq_sum += wide_t'(magnitude(d) * magnitude(d));
			end
			if (epoch_len >= 2) begin
				d = x - 2 * prev_x + prev2_x;
				d2_sum += d;
				d2_sq_sum += wide_t'(magnitude(d) * magnitude(d));
			end
			prev2_x = prev_x;
			prev_x = x;
			epoch_len++;
		end
		if (!last) return;
		res.mobility = '0;
		res.complexity = '0;
		if (len_overflow) begin
			res.status = STAT_OVF;
		end else if (epoch_len < 3) begin
			res.status = STAT_SHORT;
		end else begin
			n = epoch_len;
			p0 = n * (n - 1);
			p1 = (n - 1) * (n - 2);
			a0 = unbiased_spread(n, x_sum, x_sq_sum);
			a1 = unbiased_spread(n - 1, d1_sum, d1_sq_sum);
			res.mobility = root_of_ratio(a1 * wide_t'(p0), a0 * wide_t'(p1));
			if (n == 3) begin
				res.status = STAT_NOCPX;
			end else begin
				res.status = STAT_OK;
				p2 = (n - 2) * (n - 3);
				a2 = unbiased_spread(n - 2, d2_sum, d2_sq_sum);
				num = a2 * a0 * wide_t'(p1) * wide_t'(p1);
				den = a1 * a1 * wide_t'(p2) * wide_t'(p0);
				res.complexity = root_of_ratio(num, den);
			end
		end
		expected_results.push_back(res);
		clear_epoch();
	endfunction

	function automatic void add_sample(logic [IN_W-1:0] s, logic l, bit drain = 1'b0);
		sample_item_t it;
		it.sample = s;
		it.last = l;
		it.drain_first = drain;
		pending_samples.push_back(it);
	endfunction

	// one epoch of random content in one of several shapes
	function automatic void add_random_epoch(int len, bit drain);
		int shape, base, amp;
		logic [IN_W-1:0] s;
		shape = $urandom_range(4);
		base = $urandom_range(65535);
		amp = 1 << $urandom_range(14);
		for (int i = 0; i < len; i++) begin
			case (shape)
				0: s = IN_W'($urandom);
				1: s = base[15:0] + IN_W'($urandom_range(amp)) - IN_W'(amp / 2);
				2: s = $urandom_range(1) ? 16'h7FFF : 16'h8000;
				3: s = base[15:0];
				default: s = base[15:0] + IN_W'(i * amp);
			endcase
			add_sample(s, i == len - 1, drain && i == 0);
		end
	endfunction

	// sender: presents queued samples, predicts each accepted one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tlast <= 1'b0;
			cycle_count <= 0;
			accepted_count <= 0;
		end else begin
			cycle_count <= cycle_count + 1;
			if (s_axis_tvalid && s_axis_tready) begin
				predict_sample(offered.sample, offered.last);
				accepted_count <= accepted_count + 1;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_samples.size() != 0 &&
					!(pending_samples[0].drain_first && expected_results.size() != 0) &&
					!((cycle_count < 20000 || cycle_count > 60000) &&
					  $urandom_range(99) < 26)) begin
					offered = pending_samples.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= offered.sample;
					s_axis_tlast <= offered.last;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls, one long hold-off, checks every result transfer
	always @(posedge clk or negedge arst_n) begin
		epoch_result_t exp_res;
		int            bad;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_cycles <= 0;
			hold_done <= 1'b0;
			error_count <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				bad = 0;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, actual %h", $time, m_axis_tdata);
					bad = 1;
				end else begin
					exp_res = expected_results.pop_front();
					if (m_axis_tdata[31:0] !== exp_res.mobility) begin
						$display("%0t: mobility expected %h actual %h", $time,
							exp_res.mobility, m_axis_tdata[31:0]);
						bad = 1;
					end
					if (m_axis_tdata[63:32] !== exp_res.complexity) begin
						$display("%0t: complexity expected %h actual %h", $time,
							exp_res.complexity, m_axis_tdata[63:32]);
						bad = 1;
					end
					if (m_axis_tdata[65:64] !== exp_res.status) begin
						$display("%0t: status expected %h actual %h", $time,
							exp_res.status, m_axis_tdata[65:64]);
						bad = 1;
					end
				end
				if (bad != 0) error_count <= error_count + 1;
			end
			if (!hold_done && accepted_count >= 300) begin
				m_axis_tready <= 1'b0;
				hold_cycles <= hold_cycles + 1;
				if (hold_cycles >= 20000) hold_done <= 1'b1;
			end else begin
				m_axis_tready <= (cycle_count >= 20000 && cycle_count <= 60000) ||
					($urandom_range(99) >= 26);
			end
		end
	end

	// stimulus and end of run
	initial begin
		clear_epoch();
		arst_n = 1'b0;
		// one-sample and two-sample epochs at the field extremes
		add_sample(16'h8000, 1'b1);
		add_sample(16'h7FFF, 1'b0);
		add_sample(16'h8000, 1'b1);
		// three samples: complexity undefined
		add_sample(16'h0000, 1'b0);
		add_sample(16'h7FFF, 1'b0);
		add_sample(16'h8000, 1'b1);
		// constant signal: zero variance gives zero mobility
		for (int i = 0; i < 5; i++) add_sample(16'h1234, i == 4);
		// linear ramp after a full drain: zero first-difference variance gives zero complexity
		for (int i = 0; i < 5; i++) add_sample(16'(i * 1000 - 2000), i == 4, i == 0);
		// full-swing alternation, largest differences
		for (int i = 0; i < 6; i++) add_sample(i[0] ? 16'h7FFF : 16'h8000, i == 5);
		// random epochs, mostly well formed lengths, a few short ones
		for (int total = 0; total < 1500;) begin
			int len;
			len = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
			add_random_epoch(len, $urandom_range(19) == 0);
			total += len;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_samples.size() == 0);
		@(posedge clk);
		wait (!s_axis_tvalid && expected_results.size() == 0);
		repeat (6000) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#400ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
